>>> rtl/core/sha256h_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
`default_nettype none

package sha256h_pkg;

   typedef logic [7:0][31:0] word8_type;

   typedef struct packed {
      logic        wr_en;
      logic [5:0]  wr_pos;
      logic [7:0]  wr_byte;
      logic        start;
      logic        reinit;
      logic [2:0]  rd_idx;
   } core_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] rd_word;
   } core_stat_type;

   localparam logic [7:0] PAD_MARK     = 8'h80;
   localparam logic [5:0] LEN_POS      = 6'd56;
   localparam logic [5:0] BLOCK_END    = 6'd63;
   localparam logic [5:0] ROUND_END    = 6'd63;
   localparam logic [5:0] SCHED_FIRST  = 6'd15;
   localparam logic [2:0] WORD_END     = 3'd7;

   // element 0 holds a, element 7 holds h
   localparam word8_type IV_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sha256_byte_stream_hasher.sv
// Top level: byte packing, padding sequencer and digest output of the SHA-256 hasher.
// A byte item is taken while req_ready is high; the 64th byte of a block starts a compression.
// No byte is taken while a block compresses, since the single round unit is shared by all rounds.
// A last item adds one pad byte per cycle up to the block end, one or two compressions,
// then eight result items, one per cycle while rsp_ready is high.
// Synchronous reset loads the initial hash values and clears counts and state.
`default_nettype none

module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha256h_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PAD  = 2'd1;
   localparam logic [1:0] S_COMP = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]    state_ff;
   logic [1:0]    state_in;
   logic [5:0]    cnt_ff;
   logic [5:0]    cnt_in;
   logic [63:0]   bits_ff;
   logic [63:0]   bits_in;
   logic          first_ff;
   logic          first_in;
   logic          len_ok_ff;
   logic          len_ok_in;
   logic          fin_ff;
   logic          fin_in;
   logic          pad_ff;
   logic          pad_in;
   logic [2:0]    idx_ff;
   logic [2:0]    idx_in;
   logic [63:0]   len_shift;
   logic          len_sel;
   logic [7:0]    pad_byte;
   core_ctrl_type ctrl;
   core_stat_type stat;

   assign len_shift = bits_ff >> {~cnt_ff[2:0], 3'b000};
   assign len_sel   = (cnt_ff >= LEN_POS) && len_ok_ff && !first_ff;
   assign pad_byte  = first_ff ? PAD_MARK : (len_sel ? len_shift[7:0] : 8'h00);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bits_in      = bits_ff;
      first_in     = first_ff;
      len_ok_in    = len_ok_ff;
      fin_in       = fin_ff;
      pad_in       = pad_ff;
      idx_in       = idx_ff;
      ctrl.wr_en   = 1'b0;
      ctrl.wr_pos  = cnt_ff;
      ctrl.wr_byte = req_data_byte;
      ctrl.start   = 1'b0;
      ctrl.reinit  = 1'b0;
      ctrl.rd_idx  = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               first_in  = req_last;
               len_ok_in = 1'b0;
               fin_in    = 1'b0;
               pad_in    = req_last;
               if (req_has_byte) begin
                  ctrl.wr_en = 1'b1;
                  cnt_in     = cnt_ff + 6'd1;
                  bits_in    = bits_ff + 64'd8;
                  if (cnt_ff == BLOCK_END) begin
                     ctrl.start = 1'b1;
                     state_in   = S_COMP;
                  end else if (req_last) begin
                     state_in = S_PAD;
                  end
               end else if (req_last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_byte = pad_byte;
            cnt_in       = cnt_ff + 6'd1;
            first_in     = 1'b0;
            if (first_ff && cnt_ff < LEN_POS) begin
               len_ok_in = 1'b1;
            end
            if (cnt_ff == BLOCK_END) begin
               ctrl.start = 1'b1;
               state_in   = S_COMP;
               pad_in     = 1'b1;
               fin_in     = len_sel;
            end
         end
         S_COMP: begin
            if (stat.done) begin
               if (fin_ff) begin
                  state_in = S_OUT;
                  idx_in   = '0;
               end else if (pad_ff) begin
                  state_in  = S_PAD;
                  len_ok_in = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_END) begin
                  ctrl.reinit = 1'b1;
                  state_in    = S_IDLE;
                  cnt_in      = '0;
                  bits_in     = '0;
                  pad_in      = 1'b0;
                  fin_in      = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         bits_ff   <= '0;
         first_ff  <= 1'b0;
         len_ok_ff <= 1'b0;
         fin_ff    <= 1'b0;
         pad_ff    <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         bits_ff   <= bits_in;
         first_ff  <= first_in;
         len_ok_ff <= len_ok_in;
         fin_ff    <= fin_in;
         pad_ff    <= pad_in;
         idx_ff    <= idx_in;
      end
   end

   sha256h_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (ctrl),
      .stat_o (stat)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = stat.rd_word;
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == WORD_END);

endmodule

`default_nettype wire

>>> rtl/core/sha256h_round.sv
// One SHA-256 round step and one message schedule step.
`default_nettype none

module sha256h_round (
   input  sha256h_pkg::word8_type work_i,
   input  logic [31:0]            w_i,
   input  logic [31:0]            k_i,
   input  logic                   sched_i,
   input  logic [31:0]            tap0_i,
   input  logic [31:0]            tap1_i,
   input  logic [31:0]            tap9_i,
   input  logic [31:0]            tap14_i,
   output sha256h_pkg::word8_type work_o,
   output logic [31:0]            w_next_o
);
   import sha256h_pkg::*;

   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   assign ch  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
   assign maj = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
   assign t1  = work_i[7] + big_sigma1(work_i[4]) + ch + k_i + w_i;
   assign t2  = big_sigma0(work_i[0]) + maj;

   always_comb begin
      work_o[7] = work_i[6];
      work_o[6] = work_i[5];
      work_o[5] = work_i[4];
      work_o[4] = work_i[3] + t1;
      work_o[3] = work_i[2];
      work_o[2] = work_i[1];
      work_o[1] = work_i[0];
      work_o[0] = t1 + t2;
   end

   assign w_next_o = sched_i ? (small_sigma1(tap14_i) + tap9_i + small_sigma0(tap1_i) + tap0_i)
                             : tap0_i;

endmodule

`default_nettype wire

>>> rtl/core/sha256h_core.sv
// Block buffer, schedule window, working and chaining words with the round sequencer.
`default_nettype none

module sha256h_core (
   input  logic                       clock,
   input  logic                       reset,
   input  sha256h_pkg::core_ctrl_type ctrl_i,
   output sha256h_pkg::core_stat_type stat_o
);
   import sha256h_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PRIME = 2'd1;
   localparam logic [1:0] PH_ROUND = 2'd2;
   localparam logic [1:0] PH_FOLD  = 2'd3;

   logic [1:0]  phase_ff;
   logic [1:0]  phase_in;
   logic [5:0]  round_ff;
   logic [5:0]  round_in;
   logic [31:0] blk_ff [16];
   logic [31:0] w_ff;
   word8_type   work_ff;
   word8_type   chain_ff;
   word8_type   work_next;
   logic [31:0] w_next;
   logic        sched;
   logic        shifting;

   always_comb begin
      sched = 1'b0;
      if (phase_ff == PH_ROUND) begin
         sched = round_ff inside {[SCHED_FIRST:ROUND_END]};
      end
   end

   assign shifting = (phase_ff == PH_PRIME) || (phase_ff == PH_ROUND);

   sha256h_round u_round (
      .work_i   (work_ff),
      .w_i      (w_ff),
      .k_i      (ROUND_K[round_ff]),
      .sched_i  (sched),
      .tap0_i   (blk_ff[0]),
      .tap1_i   (blk_ff[1]),
      .tap9_i   (blk_ff[9]),
      .tap14_i  (blk_ff[14]),
      .work_o   (work_next),
      .w_next_o (w_next)
   );

   always_comb begin
      phase_in = phase_ff;
      round_in = round_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (ctrl_i.start) begin
               phase_in = PH_PRIME;
            end
         end
         PH_PRIME: begin
            phase_in = PH_ROUND;
            round_in = '0;
         end
         PH_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == ROUND_END) begin
               phase_in = PH_FOLD;
            end
         end
         PH_FOLD: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         round_ff <= '0;
         chain_ff <= IV_HASH;
      end else begin
         phase_ff <= phase_in;
         round_ff <= round_in;
         if (ctrl_i.reinit) begin
            chain_ff <= IV_HASH;
         end else if (phase_ff == PH_FOLD) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + work_ff[i];
            end
         end
      end
   end

   // buffer doubles as the schedule window during compression
   always_ff @(posedge clock) begin
      if (shifting) begin
         for (int i = 0; i < 15; i++) begin
            blk_ff[i] <= blk_ff[i+1];
         end
         blk_ff[15] <= w_next;
         w_ff       <= w_next;
      end else if (ctrl_i.wr_en) begin
         blk_ff[ctrl_i.wr_pos[5:2]][{~ctrl_i.wr_pos[1:0], 3'b111} -: 8] <= ctrl_i.wr_byte;
      end
      if (phase_ff == PH_PRIME) begin
         work_ff <= chain_ff;
      end else if (phase_ff == PH_ROUND) begin
         work_ff <= work_next;
      end
   end

   assign stat_o.done    = (phase_ff == PH_FOLD);
   assign stat_o.rd_word = chain_ff[ctrl_i.rd_idx];

endmodule

`default_nettype wire

>>> rtl/core/sha256h_checker.sv
// Port-level checks on the digest output sequence, bound to the top level.
`default_nettype none

module sha256h_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_word_index,
   input logic       rsp_last_word
);

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while digest items pending");

   a_first_word_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word_index == 3'd0)
      else $error("digest does not start at word 0");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word index not consecutive");

   a_ends_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid && req_ready)
      else $error("digest continues past last word");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_word == (rsp_word_index == 3'd7))
      else $error("last word flag misplaced");

endmodule

bind sha256_byte_stream_hasher sha256h_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_word_index (rsp_word_index),
   .rsp_last_word  (rsp_last_word)
);

`default_nettype wire
